>>> design/irpd_pkg.sv
// Types and constants for the infrared pulse-distance decoder.
`default_nettype none
package irpd_pkg;

  localparam int unsigned FRAME_BITS     = 32;
  localparam int unsigned SECOND_STEP    = 4096;
  localparam int unsigned SECOND_MODULUS = 15625;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned NUM_CFG = 8;
  localparam int unsigned CFG_IDX_W = $clog2(NUM_CFG);

  localparam logic [5:0]  FRAME_BITS_LD = 6'(FRAME_BITS);
  localparam logic [15:0] STEP_C        = 16'(SECOND_STEP);
  localparam logic [15:0] MODULUS_C     = 16'(SECOND_MODULUS);

  localparam logic [15:0] HEADER_LOW_RST  = 16'(12500 / 4);
  localparam logic [15:0] HEADER_HIGH_RST = 16'(14500 / 4);
  localparam logic [15:0] REPEAT_LOW_RST  = 16'(10400 / 4);
  localparam logic [15:0] REPEAT_HIGH_RST = 16'(12000 / 4);
  localparam logic [15:0] ZERO_LOW_RST    = 16'(950 / 4);
  localparam logic [15:0] ZERO_HIGH_RST   = 16'(1300 / 4);
  localparam logic [15:0] ONE_LOW_RST     = 16'(2000 / 4);
  localparam logic [15:0] ONE_HIGH_RST    = 16'(2500 / 4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_LOW  = 3'd0,
    REG_HEADER_HIGH = 3'd1,
    REG_REPEAT_LOW  = 3'd2,
    REG_REPEAT_HIGH = 3'd3,
    REG_ZERO_LOW    = 3'd4,
    REG_ZERO_HIGH   = 3'd5,
    REG_ONE_LOW     = 3'd6,
    REG_ONE_HIGH    = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_START = 3'd1,
    MODE_RX    = 3'd2,
    MODE_PAUSE = 3'd3,
    MODE_NOISE = 3'd4
  } mode_t;

  localparam logic FUNC_EDGE     = 1'b0;
  localparam logic FUNC_OVERFLOW = 1'b1;

  typedef struct packed {
    logic [15:0] header_low;
    logic [15:0] header_high;
    logic [15:0] repeat_low;
    logic [15:0] repeat_high;
    logic [15:0] zero_low;
    logic [15:0] zero_high;
    logic [15:0] one_low;
    logic [15:0] one_high;
  } cfg_t;

  typedef struct packed {
    logic hdr;
    logic rpt;
    logic zero;
    logic one;
  } class_t;

  typedef struct packed {
    logic        func;
    logic [15:0] capture_time;
  } in_t;

  typedef struct packed {
    logic       command_valid;
    logic [7:0] command;
    logic       second_pulse;
    logic [2:0] decoder_mode;
  } out_t;

endpackage
`default_nettype wire

>>> design/irpd_classify.sv
// Interval window classifier: header, repeat, zero and one ranges.
`default_nettype none
module irpd_classify (
  input  wire logic [15:0]    diff,
  input  wire irpd_pkg::cfg_t cfg,
  output irpd_pkg::class_t    hit
);

  // all bounds exclusive
  assign hit.hdr  = (diff > cfg.header_low) && (diff < cfg.header_high);
  assign hit.rpt  = (diff > cfg.repeat_low) && (diff < cfg.repeat_high);
  assign hit.zero = (diff > cfg.zero_low)   && (diff < cfg.zero_high);
  assign hit.one  = (diff > cfg.one_low)    && (diff < cfg.one_high);

endmodule
`default_nettype wire

>>> design/ir_pulse_distance_decoder_core.sv
// Top level of the infrared pulse-distance decoder with one-second tick.
// Input channel (in_valid/in_stall/in_data): one event per transfer, either
// a falling edge with its 16-bit capture time or a timer overflow.
// Output channel (out_valid/out_stall/out_data): exactly one result per
// event: command valid flag and byte, second pulse, decoder mode.
// Config port (cfg_we/cfg_index/cfg_wdata): writes the eight window bounds;
// write only while no event is in flight.
// An accepted event's result is registered, in the skid register if the output
// register is held. Throughput: one event per cycle while in_stall is low, set
// by the single compare-and-update pass from decoder state to output register.
// An output register plus a skid register hold results while the receiver
// stalls; in_stall rises only once both are full and falls as soon as the
// receiver takes a transfer.
// Reset (rst_n low, synchronous) returns the decoder to idle, clears the
// frame word, bit counter, edge time and tick accumulator, loads the
// default window bounds and empties both result registers.
`default_nettype none
module ir_pulse_distance_decoder_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire irpd_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output irpd_pkg::out_t                          out_data,
  input  wire logic                               cfg_we,
  input  wire logic [irpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [irpd_pkg::CFG_W-1:0]         cfg_wdata
);

  irpd_pkg::cfg_t   cfg_r;
  irpd_pkg::mode_t  mode_r, mode_nxt;
  logic [15:0]      last_time_r, last_time_nxt;
  logic [5:0]       bits_left_r, bits_left_nxt;
  logic [31:0]      frame_r, frame_nxt;
  logic             ovf_seen_r, ovf_seen_nxt;
  logic [15:0]      accum_r, accum_nxt;

  irpd_pkg::out_t   res;
  irpd_pkg::out_t   out_r, skid_r;
  logic             out_valid_r, skid_valid_r;

  logic             in_fire, out_fire;
  logic [15:0]      diff;
  logic [15:0]      acc_sum;
  logic [5:0]       bl_dec;
  logic [31:0]      frame_sh;
  irpd_pkg::class_t hit;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_fire  = out_valid_r && !out_stall;

  assign diff = in_data.capture_time - last_time_r;

  irpd_classify u_classify (
    .diff (diff),
    .cfg  (cfg_r),
    .hit  (hit)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_low  <= irpd_pkg::HEADER_LOW_RST;
      cfg_r.header_high <= irpd_pkg::HEADER_HIGH_RST;
      cfg_r.repeat_low  <= irpd_pkg::REPEAT_LOW_RST;
      cfg_r.repeat_high <= irpd_pkg::REPEAT_HIGH_RST;
      cfg_r.zero_low    <= irpd_pkg::ZERO_LOW_RST;
      cfg_r.zero_high   <= irpd_pkg::ZERO_HIGH_RST;
      cfg_r.one_low     <= irpd_pkg::ONE_LOW_RST;
      cfg_r.one_high    <= irpd_pkg::ONE_HIGH_RST;
    end else if (cfg_we) begin
      unique case (irpd_pkg::reg_idx_t'(cfg_index))
        irpd_pkg::REG_HEADER_LOW:  cfg_r.header_low  <= cfg_wdata;
        irpd_pkg::REG_HEADER_HIGH: cfg_r.header_high <= cfg_wdata;
        irpd_pkg::REG_REPEAT_LOW:  cfg_r.repeat_low  <= cfg_wdata;
        irpd_pkg::REG_REPEAT_HIGH: cfg_r.repeat_high <= cfg_wdata;
        irpd_pkg::REG_ZERO_LOW:    cfg_r.zero_low    <= cfg_wdata;
        irpd_pkg::REG_ZERO_HIGH:   cfg_r.zero_high   <= cfg_wdata;
        irpd_pkg::REG_ONE_LOW:     cfg_r.one_low     <= cfg_wdata;
        irpd_pkg::REG_ONE_HIGH:    cfg_r.one_high    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // decoder next state and result
  always_comb begin
    mode_nxt      = mode_r;
    last_time_nxt = last_time_r;
    bits_left_nxt = bits_left_r;
    frame_nxt     = frame_r;
    ovf_seen_nxt  = ovf_seen_r;
    accum_nxt     = accum_r;
    res           = '0;
    bl_dec        = bits_left_r - 6'd1;
    frame_sh      = {frame_r[30:0], hit.one && !hit.zero};
    acc_sum       = accum_r + irpd_pkg::STEP_C;

    if (in_data.func == irpd_pkg::FUNC_EDGE) begin
      last_time_nxt = in_data.capture_time;
      ovf_seen_nxt  = 1'b0;
      unique case (mode_r)
        irpd_pkg::MODE_IDLE:  mode_nxt = irpd_pkg::MODE_START;
        irpd_pkg::MODE_START: begin
          if (hit.hdr) begin
            bits_left_nxt = irpd_pkg::FRAME_BITS_LD;
            mode_nxt      = irpd_pkg::MODE_RX;
          end else if (hit.rpt) begin
            mode_nxt = irpd_pkg::MODE_PAUSE;
          end else begin
            mode_nxt = irpd_pkg::MODE_NOISE;
          end
        end
        irpd_pkg::MODE_RX: begin
          frame_nxt = frame_sh;
          if (hit.zero || hit.one) begin
            bits_left_nxt = bl_dec;
            if (bl_dec == 6'd0) begin
              mode_nxt = irpd_pkg::MODE_PAUSE;
              if ((frame_sh[31:24] == ~frame_sh[23:16]) &&
                  (frame_sh[15:8] == ~frame_sh[7:0])) begin
                res.command_valid = 1'b1;
                res.command       = frame_sh[15:8];
              end
            end
          end else begin
            mode_nxt = irpd_pkg::MODE_NOISE;
          end
        end
        irpd_pkg::MODE_PAUSE: mode_nxt = irpd_pkg::MODE_START;
        default: ;
      endcase
    end else begin
      if (ovf_seen_r) begin
        mode_nxt = irpd_pkg::MODE_IDLE;
      end
      ovf_seen_nxt = 1'b1;
      if (acc_sum >= irpd_pkg::MODULUS_C) begin
        accum_nxt        = acc_sum - irpd_pkg::MODULUS_C;
        res.second_pulse = 1'b1;
      end else begin
        accum_nxt = acc_sum;
      end
    end
    res.decoder_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= irpd_pkg::MODE_IDLE;
      last_time_r <= '0;
      bits_left_r <= '0;
      frame_r     <= '0;
      ovf_seen_r  <= 1'b0;
      accum_r     <= '0;
    end else if (in_fire) begin
      mode_r      <= mode_nxt;
      last_time_r <= last_time_nxt;
      bits_left_r <= bits_left_nxt;
      frame_r     <= frame_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      accum_r     <= accum_nxt;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  a_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
    accum_r < irpd_pkg::MODULUS_C)
    else $error("tick accumulator at or above modulus");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_cmd_pause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.command_valid) |->
      (out_r.decoder_mode == irpd_pkg::MODE_PAUSE && !out_r.second_pulse))
    else $error("command reported outside end of frame");

endmodule
`default_nettype wire
